// ===== rtl/bir_pkg.sv =====
// Shared types, constants and arithmetic helpers of the bilinear image resampler.
package bir_pkg;

   localparam int SIZE_W      = 13;
   localparam int CH_W        = 3;
   localparam int CHAN_W      = 2;
   localparam int COORD_W     = 12;
   localparam int INDEX_W     = 16;
   localparam int VALUE_W     = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int FRAC_W      = 16;
   localparam int NUM_W       = COORD_W + SIZE_W;
   localparam int DIVD_W      = NUM_W + FRAC_W + 1;
   localparam int ROW_W       = 2 * SIZE_W;
   localparam int PIX_W       = ROW_W + 1;
   localparam int IDX_W       = PIX_W + CH_W;
   localparam int DIFF_W      = VALUE_W + 1;
   localparam int PROD_W      = FRAC_W + 1 + DIFF_W;
   localparam int RND_W       = PROD_W - FRAC_W;
   localparam int QUEUE_DEPTH = 2;

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SRC_WIDTH     = 3'd0,
      CSR_SRC_HEIGHT    = 3'd1,
      CSR_CHANNEL_COUNT = 3'd2,
      CSR_DST_WIDTH     = 3'd3,
      CSR_DST_HEIGHT    = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_LOAD,
      KIND_FAIL,
      KIND_SAMPLE
   } kind_type;

   typedef struct packed {
      logic                      command;
      logic [INDEX_W-1:0]        sample_index;
      logic signed [VALUE_W-1:0] sample_value;
      logic [COORD_W-1:0]        out_x;
      logic [COORD_W-1:0]        out_y;
      logic [CHAN_W-1:0]         channel;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] result_value;
      logic                      error;
   } rsp_type;

   typedef struct packed {
      logic [SIZE_W-1:0] src_width;
      logic [SIZE_W-1:0] src_height;
      logic [CH_W-1:0]   channel_count;
      logic [SIZE_W-1:0] dst_width;
      logic [SIZE_W-1:0] dst_height;
   } cfg_type;

   typedef struct packed {
      kind_type kind;
      req_type  req;
   } entry_type;

   typedef struct packed {
      logic [SIZE_W-1:0] ip;
      logic [FRAC_W-1:0] frac;
   } coord_type;

   // Quotient carries one extra fraction bit; add one and halve to round half up.
   function automatic coord_type map_coord(logic [DIVD_W-1:0] q, logic [SIZE_W-1:0] src,
                                           logic bypass);
      logic [DIVD_W:0]        inc;
      logic [DIVD_W-1:0]      t;
      logic [RND_W-1:0]       dummy;
      logic [DIVD_W-FRAC_W-1:0] ip;
      coord_type              c;
      dummy = '0;
      inc = {1'b0, q} + (DIVD_W+1)'(1);
      t   = inc[DIVD_W:1];
      ip  = t[DIVD_W-1:FRAC_W];
      c   = '0;
      if (bypass || dummy != '0) begin
         c = '0;
      end else if (ip > (DIVD_W-FRAC_W)'(src - SIZE_W'(1))) begin
         c.ip   = src - SIZE_W'(1);
         c.frac = '0;
      end else begin
         c.ip   = ip[SIZE_W-1:0];
         c.frac = t[FRAC_W-1:0];
      end
      return c;
   endfunction

   // a + round(p / 2^16), half towards plus infinity.
   function automatic logic signed [VALUE_W-1:0] blend_add(logic signed [VALUE_W-1:0] a,
                                                           logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] s;
      logic signed [RND_W-1:0]  r;
      logic signed [RND_W-1:0]  sum;
      s   = p + PROD_W'(1 << (FRAC_W - 1));
      r   = s[PROD_W-1:FRAC_W];
      sum = RND_W'(a) + r;
      return sum[VALUE_W-1:0];
   endfunction

endpackage

// ===== rtl/bilinear_image_resampler.sv =====
// Top level of the bilinear image resampler: registers, front end, queue and back end.
//
// Usage: input words go in on req_word with push/full; a word is taken at a clock edge
// with push high and full low. A load word (command 0) writes one Q16.16 sample into the
// store; a sample word (command 1) asks for output pixel (out_x, out_y, channel) of the
// image resized to dst_width x dst_height. Every word gives exactly one result word on
// rsp_word, oldest first, shown while empty is low and taken with pop.
// Write sizes through csr_write/csr_index/csr_data only while the block is idle.
// A load needs only the store write and the result register; a sample request passes
// the radix-2 coordinate divider (42 steps, x and y in parallel), four reads through
// the single store read port and the blend states on the shared blend multiplier.
// The front end takes a new word only once the last one is in the queue; the back end
// takes the next queue entry only once the last result has moved to the result word.
// Reset empties the queue and the result register and sets all sizes to 1; the store keeps
// its contents and is undefined until written.
// When the receiver stalls, the result word holds; one more finished word waits in the
// back end, the queue fills and full then holds off further words.
module bilinear_image_resampler #(
   parameter int MAX_SAMPLES  = 65536,
   parameter int MAX_CHANNELS = 4,
   parameter int MAX_DIM      = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  bir_pkg::req_type                  req_word,
   output logic                              full,
   output logic                              empty,
   input  logic                              pop,
   output bir_pkg::rsp_type                  rsp_word,
   input  logic                              csr_write,
   input  logic [bir_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bir_pkg::SIZE_W-1:0]        csr_data
);

   bir_pkg::cfg_type   cfg_ff;
   logic               q_push;
   logic               q_full;
   logic               q_pop;
   logic               q_empty;
   bir_pkg::entry_type q_in;
   bir_pkg::entry_type q_out;

   // size registers; drop writes to unused indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.src_width     <= bir_pkg::SIZE_W'(1);
         cfg_ff.src_height    <= bir_pkg::SIZE_W'(1);
         cfg_ff.channel_count <= bir_pkg::CH_W'(1);
         cfg_ff.dst_width     <= bir_pkg::SIZE_W'(1);
         cfg_ff.dst_height    <= bir_pkg::SIZE_W'(1);
      end else if (csr_write) begin
         unique case (csr_index)
            bir_pkg::CSR_SRC_WIDTH:     cfg_ff.src_width     <= csr_data;
            bir_pkg::CSR_SRC_HEIGHT:    cfg_ff.src_height    <= csr_data;
            bir_pkg::CSR_CHANNEL_COUNT: cfg_ff.channel_count <= csr_data[bir_pkg::CH_W-1:0];
            bir_pkg::CSR_DST_WIDTH:     cfg_ff.dst_width     <= csr_data;
            bir_pkg::CSR_DST_HEIGHT:    cfg_ff.dst_height    <= csr_data;
            default: ;
         endcase
      end
   end

   // classify words and check sizes against the limits
   bir_front #(
      .MAX_SAMPLES  (MAX_SAMPLES),
      .MAX_CHANNELS (MAX_CHANNELS),
      .MAX_DIM      (MAX_DIM)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .push     (push),
      .req_word (req_word),
      .full     (full),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_entry  (q_in)
   );

   // decouple front and back so each stalls on its own
   bir_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .entry_in  (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .entry_out (q_out),
      .empty     (q_empty)
   );

   // store, divide, fetch neighbors, blend, hold result
   bir_back #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_empty  (q_empty),
      .q_entry  (q_out),
      .q_pop    (q_pop),
      .pop      (pop),
      .empty    (empty),
      .rsp_word (rsp_word)
   );

endmodule

// ===== rtl/bir_front.sv =====
// Front end: accepts a word, checks sizes and coordinates, classifies it for the back end.
module bir_front #(
   parameter int MAX_SAMPLES  = 65536,
   parameter int MAX_CHANNELS = 4,
   parameter int MAX_DIM      = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  bir_pkg::cfg_type   cfg,
   input  logic               push,
   input  bir_pkg::req_type   req_word,
   output logic               full,
   input  logic               q_full,
   output logic               q_push,
   output bir_pkg::entry_type q_entry
);

   typedef enum logic [1:0] {F_IDLE, F_CHK, F_CLASSIFY, F_PUSH} state_type;

   state_type                         state_ff;
   bir_pkg::req_type                  item_ff;
   bir_pkg::kind_type                 kind_ff;
   logic                              range_ok_ff;
   logic [bir_pkg::ROW_W-1:0]         area_src_ff;
   logic [bir_pkg::ROW_W-1:0]         area_dst_ff;

   logic                              range_ok_in;
   logic [bir_pkg::ROW_W+bir_pkg::CH_W-1:0] volume;
   bir_pkg::kind_type                 kind_in;

   always_comb begin
      range_ok_in = cfg.src_width != '0 && 32'(cfg.src_width) <= 32'(MAX_DIM) &&
                    cfg.src_height != '0 && 32'(cfg.src_height) <= 32'(MAX_DIM) &&
                    cfg.channel_count != '0 &&
                    32'(cfg.channel_count) <= 32'(MAX_CHANNELS) &&
                    cfg.dst_width != '0 && 32'(cfg.dst_width) <= 32'(MAX_DIM) &&
                    cfg.dst_height != '0 && 32'(cfg.dst_height) <= 32'(MAX_DIM);
      volume = (bir_pkg::ROW_W+bir_pkg::CH_W)'(area_src_ff) *
               (bir_pkg::ROW_W+bir_pkg::CH_W)'(cfg.channel_count);
      if (item_ff.command == bir_pkg::CMD_LOAD) begin
         kind_in = (32'(item_ff.sample_index) < 32'(MAX_SAMPLES)) ?
                   bir_pkg::KIND_LOAD : bir_pkg::KIND_FAIL;
      end else if (range_ok_ff && 32'(volume) <= 32'(MAX_SAMPLES) &&
                   32'(area_dst_ff) <= 32'(MAX_SAMPLES) &&
                   bir_pkg::SIZE_W'(item_ff.out_x) < cfg.dst_width &&
                   bir_pkg::SIZE_W'(item_ff.out_y) < cfg.dst_height &&
                   bir_pkg::CH_W'(item_ff.channel) < cfg.channel_count) begin
         kind_in = bir_pkg::KIND_SAMPLE;
      end else begin
         kind_in = bir_pkg::KIND_FAIL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         unique case (state_ff)
            F_IDLE: begin
               if (push) begin
                  item_ff  <= req_word;
                  state_ff <= F_CHK;
               end
            end
            F_CHK: begin
               area_src_ff <= bir_pkg::ROW_W'(cfg.src_width) * bir_pkg::ROW_W'(cfg.src_height);
               area_dst_ff <= bir_pkg::ROW_W'(cfg.dst_width) * bir_pkg::ROW_W'(cfg.dst_height);
               range_ok_ff <= range_ok_in;
               state_ff    <= F_CLASSIFY;
            end
            F_CLASSIFY: begin
               kind_ff  <= kind_in;
               state_ff <= F_PUSH;
            end
            F_PUSH: begin
               if (!q_full) begin
                  state_ff <= F_IDLE;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

   assign full          = (state_ff != F_IDLE);
   assign q_push        = (state_ff == F_PUSH) && !q_full;
   assign q_entry.kind  = kind_ff;
   assign q_entry.req   = item_ff;

endmodule

// ===== rtl/bir_queue.sv =====
// Short queue of classified words between front and back end.
module bir_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  bir_pkg::entry_type entry_in,
   output logic               full,
   input  logic               pop,
   output bir_pkg::entry_type entry_out,
   output logic               empty
);

   localparam int PTR_W = (bir_pkg::QUEUE_DEPTH > 1) ? $clog2(bir_pkg::QUEUE_DEPTH) : 1;

   bir_pkg::entry_type entries_ff [bir_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W:0]     count_ff;
   logic               do_push;
   logic               do_pop;

   assign full      = (count_ff == (PTR_W+1)'(bir_pkg::QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign entry_out = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(bir_pkg::QUEUE_DEPTH - 1)) ? '0 :
                         wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(bir_pkg::QUEUE_DEPTH - 1)) ? '0 :
                         rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + (PTR_W+1)'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - (PTR_W+1)'(1);
         end
      end
   end

endmodule

// ===== rtl/bir_back.sv =====
// Back end: sample store, coordinate dividers, neighbor fetch, blend and result register.
module bir_back #(
   parameter int MAX_SAMPLES = 65536
) (
   input  logic               clock,
   input  logic               reset,
   input  bir_pkg::cfg_type   cfg,
   input  logic               q_empty,
   input  bir_pkg::entry_type q_entry,
   output logic               q_pop,
   input  logic               pop,
   output logic               empty,
   output bir_pkg::rsp_type   rsp_word
);

   localparam int AW    = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int CNT_W = $clog2(bir_pkg::DIVD_W);

   typedef enum logic [3:0] {
      B_IDLE, B_DIV, B_COORD, B_ROWS, B_PIX, B_IDX, B_READ,
      B_MUL0, B_MUL1, B_MUL2, B_MUL3, B_MUL4, B_DONE
   } state_type;

   typedef struct packed {
      logic [bir_pkg::SIZE_W-1:0] rem;
      logic [bir_pkg::DIVD_W-1:0] q;
   } div_type;

   function automatic div_type div_step(div_type s, logic [bir_pkg::SIZE_W-1:0] den);
      logic [bir_pkg::SIZE_W:0] sh;
      div_type                  n;
      sh = {s.rem, s.q[bir_pkg::DIVD_W-1]};
      if (sh >= {1'b0, den}) begin
         n.rem = bir_pkg::SIZE_W'(sh - {1'b0, den});
         n.q   = {s.q[bir_pkg::DIVD_W-2:0], 1'b1};
      end else begin
         n.rem = sh[bir_pkg::SIZE_W-1:0];
         n.q   = {s.q[bir_pkg::DIVD_W-2:0], 1'b0};
      end
      return n;
   endfunction

   state_type                         state_ff;
   div_type                           divx_ff;
   div_type                           divy_ff;
   logic [bir_pkg::SIZE_W-1:0]        denx_ff;
   logic [bir_pkg::SIZE_W-1:0]        deny_ff;
   logic                              bypx_ff;
   logic                              bypy_ff;
   logic [CNT_W-1:0]                  cnt_ff;
   logic [bir_pkg::CHAN_W-1:0]        ch_ff;
   logic [bir_pkg::SIZE_W-1:0]        x0_ff;
   logic [bir_pkg::SIZE_W-1:0]        x1_ff;
   logic [bir_pkg::SIZE_W-1:0]        y0_ff;
   logic [bir_pkg::SIZE_W-1:0]        y1_ff;
   logic [bir_pkg::FRAC_W-1:0]        tx_ff;
   logic [bir_pkg::FRAC_W-1:0]        ty_ff;
   logic [bir_pkg::ROW_W-1:0]         row0_ff;
   logic [bir_pkg::ROW_W-1:0]         row1_ff;
   logic [bir_pkg::PIX_W-1:0]         pix_ff [4];
   logic [bir_pkg::IDX_W-1:0]         idx_ff [4];
   logic [2:0]                        rd_cnt_ff;
   logic signed [bir_pkg::VALUE_W-1:0] v_ff [4];
   logic signed [bir_pkg::VALUE_W-1:0] h0_ff;
   logic signed [bir_pkg::VALUE_W-1:0] h1_ff;
   logic signed [bir_pkg::PROD_W-1:0]  prod_ff;
   bir_pkg::rsp_type                  res_ff;
   bir_pkg::rsp_type                  rsp_ff;
   logic                              rsp_valid_ff;

   logic signed [bir_pkg::VALUE_W-1:0] mem [MAX_SAMPLES];
   logic signed [bir_pkg::VALUE_W-1:0] mem_q_ff;
   logic                              wr_en;
   logic [AW-1:0]                     wr_addr;
   logic [AW-1:0]                     rd_addr;

   bir_pkg::coord_type                cx;
   bir_pkg::coord_type                cy;
   logic [bir_pkg::NUM_W-1:0]         numx;
   logic [bir_pkg::NUM_W-1:0]         numy;
   logic [bir_pkg::FRAC_W-1:0]        mul_t;
   logic signed [bir_pkg::VALUE_W-1:0] mul_a;
   logic signed [bir_pkg::VALUE_W-1:0] mul_b;
   logic signed [bir_pkg::DIFF_W-1:0]  mul_d;
   logic signed [bir_pkg::PROD_W-1:0]  prod_in;

   assign q_pop   = (state_ff == B_IDLE) && !q_empty;
   assign wr_en   = q_pop && (q_entry.kind == bir_pkg::KIND_LOAD);
   assign wr_addr = AW'(q_entry.req.sample_index);
   assign rd_addr = AW'(idx_ff[rd_cnt_ff[1:0]]);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= q_entry.req.sample_value;
      end
      mem_q_ff <= mem[rd_addr];
   end

   always_comb begin
      numx = bir_pkg::NUM_W'(q_entry.req.out_x) *
             bir_pkg::NUM_W'(cfg.src_width - bir_pkg::SIZE_W'(1));
      numy = bir_pkg::NUM_W'(q_entry.req.out_y) *
             bir_pkg::NUM_W'(cfg.src_height - bir_pkg::SIZE_W'(1));
      cx   = bir_pkg::map_coord(divx_ff.q, cfg.src_width, bypx_ff);
      cy   = bir_pkg::map_coord(divy_ff.q, cfg.src_height, bypy_ff);
      unique case (state_ff)
         B_MUL1: begin
            mul_t = tx_ff;
            mul_a = v_ff[2];
            mul_b = v_ff[3];
         end
         B_MUL3: begin
            mul_t = ty_ff;
            mul_a = h0_ff;
            mul_b = h1_ff;
         end
         default: begin
            mul_t = tx_ff;
            mul_a = v_ff[0];
            mul_b = v_ff[1];
         end
      endcase
      mul_d   = bir_pkg::DIFF_W'(mul_b) - bir_pkg::DIFF_W'(mul_a);
      prod_in = $signed({1'b0, mul_t}) * mul_d;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drop the shown word once taken, unless a new one replaces it this cycle
         if (pop && rsp_valid_ff && state_ff != B_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            B_IDLE: begin
               if (!q_empty) begin
                  unique case (q_entry.kind)
                     bir_pkg::KIND_LOAD: begin
                        res_ff   <= '{result_value: '0, error: 1'b0};
                        state_ff <= B_DONE;
                     end
                     bir_pkg::KIND_SAMPLE: begin
                        divx_ff  <= '{rem: '0, q: {numx, (bir_pkg::FRAC_W+1)'(0)}};
                        divy_ff  <= '{rem: '0, q: {numy, (bir_pkg::FRAC_W+1)'(0)}};
                        denx_ff  <= cfg.dst_width - bir_pkg::SIZE_W'(1);
                        deny_ff  <= cfg.dst_height - bir_pkg::SIZE_W'(1);
                        bypx_ff  <= (cfg.src_width <= bir_pkg::SIZE_W'(1)) ||
                                    (cfg.dst_width <= bir_pkg::SIZE_W'(1));
                        bypy_ff  <= (cfg.src_height <= bir_pkg::SIZE_W'(1)) ||
                                    (cfg.dst_height <= bir_pkg::SIZE_W'(1));
                        ch_ff    <= q_entry.req.channel;
                        cnt_ff   <= CNT_W'(bir_pkg::DIVD_W - 1);
                        state_ff <= B_DIV;
                     end
                     default: begin
                        res_ff   <= '{result_value: '0, error: 1'b1};
                        state_ff <= B_DONE;
                     end
                  endcase
               end
            end
            B_DIV: begin
               divx_ff <= div_step(divx_ff, denx_ff);
               divy_ff <= div_step(divy_ff, deny_ff);
               if (cnt_ff == '0) begin
                  state_ff <= B_COORD;
               end else begin
                  cnt_ff <= cnt_ff - CNT_W'(1);
               end
            end
            B_COORD: begin
               x0_ff <= cx.ip;
               tx_ff <= cx.frac;
               y0_ff <= cy.ip;
               ty_ff <= cy.frac;
               x1_ff <= ({1'b0, cx.ip} + (bir_pkg::SIZE_W+1)'(1) < {1'b0, cfg.src_width}) ?
                        cx.ip + bir_pkg::SIZE_W'(1) : cfg.src_width - bir_pkg::SIZE_W'(1);
               y1_ff <= ({1'b0, cy.ip} + (bir_pkg::SIZE_W+1)'(1) < {1'b0, cfg.src_height}) ?
                        cy.ip + bir_pkg::SIZE_W'(1) : cfg.src_height - bir_pkg::SIZE_W'(1);
               state_ff <= B_ROWS;
            end
            B_ROWS: begin
               row0_ff  <= bir_pkg::ROW_W'(y0_ff) * bir_pkg::ROW_W'(cfg.src_width);
               row1_ff  <= bir_pkg::ROW_W'(y1_ff) * bir_pkg::ROW_W'(cfg.src_width);
               state_ff <= B_PIX;
            end
            B_PIX: begin
               pix_ff[0] <= bir_pkg::PIX_W'(row0_ff) + bir_pkg::PIX_W'(x0_ff);
               pix_ff[1] <= bir_pkg::PIX_W'(row0_ff) + bir_pkg::PIX_W'(x1_ff);
               pix_ff[2] <= bir_pkg::PIX_W'(row1_ff) + bir_pkg::PIX_W'(x0_ff);
               pix_ff[3] <= bir_pkg::PIX_W'(row1_ff) + bir_pkg::PIX_W'(x1_ff);
               state_ff  <= B_IDX;
            end
            B_IDX: begin
               for (int k = 0; k < 4; k++) begin
                  idx_ff[k] <= bir_pkg::IDX_W'(pix_ff[k]) * bir_pkg::IDX_W'(cfg.channel_count) +
                               bir_pkg::IDX_W'(ch_ff);
               end
               rd_cnt_ff <= '0;
               state_ff  <= B_READ;
            end
            B_READ: begin
               // data of the address issued last cycle lands in mem_q_ff
               if (rd_cnt_ff != '0) begin
                  v_ff[2'(rd_cnt_ff - 3'd1)] <= mem_q_ff;
               end
               if (rd_cnt_ff == 3'd4) begin
                  state_ff <= B_MUL0;
               end else begin
                  rd_cnt_ff <= rd_cnt_ff + 3'd1;
               end
            end
            B_MUL0: begin
               prod_ff  <= prod_in;
               state_ff <= B_MUL1;
            end
            B_MUL1: begin
               h0_ff    <= bir_pkg::blend_add(v_ff[0], prod_ff);
               prod_ff  <= prod_in;
               state_ff <= B_MUL2;
            end
            B_MUL2: begin
               h1_ff    <= bir_pkg::blend_add(v_ff[2], prod_ff);
               state_ff <= B_MUL3;
            end
            B_MUL3: begin
               prod_ff  <= prod_in;
               state_ff <= B_MUL4;
            end
            B_MUL4: begin
               res_ff   <= '{result_value: bir_pkg::blend_add(h0_ff, prod_ff), error: 1'b0};
               state_ff <= B_DONE;
            end
            B_DONE: begin
               if (!rsp_valid_ff || pop) begin
                  rsp_ff       <= res_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   assign empty    = !rsp_valid_ff;
   assign rsp_word = rsp_ff;

endmodule
